>>> hw/rtl/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

    // token mode
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_OPER = 1'b1;

    // operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_FULL      = 3'd3,
        ST_MALFORMED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_LOAD_UP = 2'd1,
        CELL_LOAD_DN = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic        start;
        logic        is_div;
    } t_md_req;

    typedef struct packed {
        logic        mode;
        logic [30:0] operand_value;
        logic [1:0]  op_code;
        logic        last_token;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [6:0]         stack_depth;
        logic [2:0]         status;
        logic               expression_done;
    } t_out_word;

endpackage

>>> hw/rtl/postfix_stack_evaluator.sv
`timescale 1ns / 1ps

// Postfix expression evaluator on a stack built as a row of shifting cells.
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one token word:
// a push token places operand_value on top, an operator token pops the top
// A and the entry below B and pushes B op A (add, subtract, multiply,
// truncating divide, all wrapping at VALUE_WIDTH bits).
// Output channel (o_out_valid / i_out_ready / o_out_word) returns one word
// per token: top value, depth, status and whether the expression closed.
// Push, add, subtract and any token that errors or is ignored go from accept
// straight to the report state, which writes the result word out, and a new
// token is taken only once the evaluator is back in idle. Multiply and divide
// run through a bit-serial unit, one bit a cycle: the evaluator waits in the
// calc state until the unit is done, then puts the result in place and reports.
// The first error is latched and later tokens are ignored until the token
// marked last, which reports and then empties the stack and clears the error.
// Reset empties the stack and clears the error; no clearing pass is needed.
// When the receiver stalls, one result waits in the output register and one
// more in a skid register; input stalls while the skid is full or a token is in work.
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int W   = VALUE_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_REPORT
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [SPW-1:0]   r_sp;
    logic [SPW-1:0]   n_sp;
    t_status          r_err;
    t_status          n_err;
    logic             r_last;
    logic             r_out_valid;
    t_out_word        r_out_word;
    logic             r_skid_valid;
    t_out_word        r_skid_word;

    logic [W-1:0]     s_val [STACK_DEPTH];
    logic [W-1:0]     s_cell0_in;
    t_cell_op         s_op_top;
    t_cell_op         s_op_rest;
    t_md_req          s_md_req;
    logic             s_md_done;
    logic [W-1:0]     s_md_result;
    logic             s_accept;
    logic             s_out_free;
    t_status          s_status;
    t_out_word        s_res;
    logic signed [W-1:0] s_top_s;

    assign o_in_ready = (r_state == S_IDLE) && !r_skid_valid;
    assign s_accept   = i_in_valid && o_in_ready;

    // ---------------- stack cells ----------------
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        logic [W-1:0] w_up;
        logic [W-1:0] w_dn;
        if (gi == 0) begin : g_head
            assign w_up = s_cell0_in;
        end else begin : g_body
            assign w_up = s_val[gi-1];
        end
        if (gi == STACK_DEPTH - 1) begin : g_tail
            assign w_dn = s_val[gi];
        end else begin : g_inner
            assign w_dn = s_val[gi+1];
        end
        pse_cell #(
            .WIDTH (W)
        ) u_cell (
            .i_clk (i_clk),
            .i_op  ((gi == 0) ? s_op_top : s_op_rest),
            .i_up  (w_up),
            .i_dn  (w_dn),
            .o_val (s_val[gi])
        );
    end

    pse_muldiv #(
        .WIDTH (W)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (s_md_req),
        .i_below  (s_val[1]),
        .i_top    (s_val[0]),
        .o_done   (s_md_done),
        .o_result (s_md_result)
    );

    // ---------------- control ----------------
    always_comb begin
        n_state          = r_state;
        n_sp             = r_sp;
        n_err            = r_err;
        s_op_top         = CELL_HOLD;
        s_op_rest        = CELL_HOLD;
        s_cell0_in       = s_md_result;
        s_md_req.start   = 1'b0;
        s_md_req.is_div  = (i_in_word.op_code == OP_DIV);

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_REPORT;
                    if (r_err == ST_OK) begin
                        if (i_in_word.mode == MODE_PUSH) begin
                            if (r_sp >= SPW'(STACK_DEPTH)) begin
                                n_err = ST_FULL;
                            end else begin
                                s_cell0_in = W'(i_in_word.operand_value);
                                s_op_top   = CELL_LOAD_UP;
                                s_op_rest  = CELL_LOAD_UP;
                                n_sp       = r_sp + SPW'(1);
                            end
                        end else if (r_sp < SPW'(2)) begin
                            n_err = ST_UNDERFLOW;
                        end else begin
                            case (i_in_word.op_code)
                                OP_ADD: begin
                                    s_cell0_in = s_val[1] + s_val[0];
                                    s_op_top   = CELL_LOAD_UP;
                                    s_op_rest  = CELL_LOAD_DN;
                                    n_sp       = r_sp - SPW'(1);
                                end
                                OP_SUB: begin
                                    s_cell0_in = s_val[1] - s_val[0];
                                    s_op_top   = CELL_LOAD_UP;
                                    s_op_rest  = CELL_LOAD_DN;
                                    n_sp       = r_sp - SPW'(1);
                                end
                                default: begin
                                    if (i_in_word.op_code == OP_DIV && s_val[0] == '0) begin
                                        n_err = ST_DIVZERO;
                                    end else begin
                                        s_md_req.start = 1'b1;
                                        n_state        = S_CALC;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            S_CALC: begin
                if (s_md_done) begin
                    s_op_top  = CELL_LOAD_UP;
                    s_op_rest = CELL_LOAD_DN;
                    n_sp      = r_sp - SPW'(1);
                    n_state   = S_REPORT;
                end
            end
            S_REPORT: begin
                n_state = S_IDLE;
                if (r_last) begin
                    n_sp  = '0;
                    n_err = ST_OK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result word, formed from the stack after the token took effect
    assign s_top_s = s_val[0];
    always_comb begin
        if (r_err != ST_OK) begin
            s_status = r_err;
        end else if (r_last && r_sp != SPW'(1)) begin
            s_status = ST_MALFORMED;
        end else begin
            s_status = ST_OK;
        end
        s_res.top_value       = (r_sp != '0) ? 32'(s_top_s) : '0;
        s_res.stack_depth     = 7'(r_sp);
        s_res.status          = s_status;
        s_res.expression_done = r_last;
    end

    assign s_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sp         <= '0;
            r_err        <= ST_OK;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_err   <= n_err;
            if (s_accept) begin
                r_last <= i_in_word.last_token;
            end
            if (s_out_free) begin
                if (r_skid_valid) begin
                    r_out_word   <= r_skid_word;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (r_state == S_REPORT) begin
                    r_out_word  <= s_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (r_state == S_REPORT) begin
                r_skid_word  <= s_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------- assertions ----------------
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with output register empty");

    a_md_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_md_done |-> (r_state == S_CALC))
        else $error("multiply/divide finished outside of calc state");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT && r_last) |=> (r_sp == '0 && r_err == ST_OK))
        else $error("closing token did not clear the stack");

endmodule

>>> hw/rtl/pse_cell.sv
`timescale 1ns / 1ps

module pse_cell
    import pse_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  t_cell_op         i_op,
    input  logic [WIDTH-1:0] i_up,
    input  logic [WIDTH-1:0] i_dn,
    output logic [WIDTH-1:0] o_val
);

    logic [WIDTH-1:0] r_val;
    logic [WIDTH-1:0] n_val;

    always_comb begin
        unique case (i_op)
            CELL_LOAD_UP: n_val = i_up;
            CELL_LOAD_DN: n_val = i_dn;
            default:      n_val = r_val;
        endcase
    end

    // stack entries carry no reset, only entries below the depth are read
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

>>> hw/rtl/pse_muldiv.sv
`timescale 1ns / 1ps

module pse_muldiv
    import pse_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_md_req          i_req,
    input  logic [WIDTH-1:0] i_below,
    input  logic [WIDTH-1:0] i_top,
    output logic             o_done,
    output logic [WIDTH-1:0] o_result
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_div;
    logic             r_neg;

    logic [WIDTH-1:0] s_mag_top;
    logic [WIDTH-1:0] s_mag_below;
    logic [WIDTH:0]   s_rem_sh;
    logic             s_qbit;
    logic [WIDTH-1:0] s_quo;

    assign s_mag_top   = i_top[WIDTH-1]   ? (~i_top + WIDTH'(1))   : i_top;
    assign s_mag_below = i_below[WIDTH-1] ? (~i_below + WIDTH'(1)) : i_below;

    // restoring divide step: remainder in r_acc, dividend shifts out of r_y
    // while quotient bits shift in
    assign s_rem_sh = {r_acc, r_y[WIDTH-1]};
    assign s_qbit   = (s_rem_sh >= {1'b0, r_x});

    assign s_quo    = r_neg ? (~r_y + WIDTH'(1)) : r_y;
    assign o_result = r_div ? s_quo : r_acc;
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_div  <= i_req.is_div;
                r_acc  <= '0;
                r_neg  <= i_top[WIDTH-1] ^ i_below[WIDTH-1];
                if (i_req.is_div) begin
                    r_x <= s_mag_top;
                    r_y <= s_mag_below;
                end else begin
                    r_x <= i_below;
                    r_y <= i_top;
                end
            end else if (r_busy) begin
                if (r_div) begin
                    r_acc <= s_qbit ? WIDTH'(s_rem_sh - {1'b0, r_x}) : WIDTH'(s_rem_sh);
                    r_y   <= {r_y[WIDTH-2:0], s_qbit};
                end else begin
                    // shift-add multiply, low bits only since the result wraps
                    r_acc <= r_acc + (r_y[0] ? r_x : '0);
                    r_x   <= {r_x[WIDTH-2:0], 1'b0};
                    r_y   <= {1'b0, r_y[WIDTH-1:1]};
                end
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
